FILE: hw/rtl/array_list_insert_remove_assert.svh
// ----------------------------------------------------------------------------
// array_list_insert_remove_assert.svh
// Assertion macros used by the list block checker.
// ----------------------------------------------------------------------------
`ifndef ARRAY_LIST_INSERT_REMOVE_ASSERT_SVH
`define ARRAY_LIST_INSERT_REMOVE_ASSERT_SVH

// same-cycle implication
`define ALIR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ALIR_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: hw/rtl/alir_pkg.sv
// ----------------------------------------------------------------------------
// alir_pkg
// Types and constants of the array list block.
// ----------------------------------------------------------------------------
package alir_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int RESULT_LIMIT = 16;

   localparam logic [2:0] OP_INS_END   = 3'd0;
   localparam logic [2:0] OP_INS_FRONT = 3'd1;
   localparam logic [2:0] OP_INS_AT    = 3'd2;
   localparam logic [2:0] OP_REM_END   = 3'd3;
   localparam logic [2:0] OP_REM_FRONT = 3'd4;
   localparam logic [2:0] OP_REM_AT    = 3'd5;
   localparam logic [2:0] OP_LIST      = 3'd6;
   localparam logic [2:0] OP_SIZE      = 3'd7;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_FULL   = 2'd1;
   localparam logic [1:0] ST_EMPTY  = 2'd2;
   localparam logic [1:0] ST_BADPOS = 2'd3;

   typedef struct packed {
      logic [2:0] opcode;
      logic [7:0] element_in;
      logic [4:0] position;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] element_out;
      logic [4:0] count;
      logic       last;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      DP_HOLD,
      DP_INSERT,
      DP_REMOVE,
      DP_ROTATE
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [7:0] elem;
      logic       load_rsp;
      logic [1:0] status;
      logic       from_cell;
      logic       last;
   } dp_cmd_type;

endpackage

FILE: hw/rtl/alir_dpath.sv
// ----------------------------------------------------------------------------
// alir_dpath
// Element cells with parallel shift and rotate, element count, result register.
// ----------------------------------------------------------------------------
module alir_dpath #(
   parameter int CAPACITY = alir_pkg::CAPACITY_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  alir_pkg::dp_cmd_type               cmd,
   input  logic [$clog2(CAPACITY)-1:0]        idx,
   output logic [$clog2(CAPACITY+1)-1:0]      count,
   output alir_pkg::rsp_payload_type          rsp_data
);
   import alir_pkg::*;

   localparam int IW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = ((CW > 5) ? CW : 5) + 1;

   logic [7:0]      cells_ff [CAPACITY];
   logic [7:0]      cells_in [CAPACITY];
   logic [CW-1:0]   count_ff;
   logic [CW-1:0]   count_in;
   logic [CW-1:0]   count_dec;
   logic [IW-1:0]   last_idx;
   logic [CMPW-1:0] count_ext;
   rsp_payload_type rsp_ff;

   assign count_dec = count_ff - CW'(1);
   assign last_idx  = count_dec[IW-1:0];

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [7:0] lower;
      logic [7:0] upper;
      if (g == 0) begin : g_lo0
         assign lower = cells_ff[g];
      end else begin : g_lo
         assign lower = cells_ff[g-1];
      end
      if (g == CAPACITY - 1) begin : g_hi0
         assign upper = cells_ff[g];
      end else begin : g_hi
         assign upper = cells_ff[g+1];
      end
      always_comb begin
         unique case (cmd.op)
            DP_INSERT: begin
               if (IW'(g) > idx) cells_in[g] = lower;
               else if (IW'(g) == idx) cells_in[g] = cmd.elem;
               else cells_in[g] = cells_ff[g];
            end
            DP_REMOVE: begin
               if (IW'(g) >= idx) cells_in[g] = upper;
               else cells_in[g] = cells_ff[g];
            end
            DP_ROTATE: begin
               if (IW'(g) == last_idx) cells_in[g] = cells_ff[0];
               else cells_in[g] = upper;
            end
            default: cells_in[g] = cells_ff[g];
         endcase
      end
   end

   always_comb begin
      unique case (cmd.op)
         DP_INSERT: count_in = count_ff + CW'(1);
         DP_REMOVE: count_in = count_dec;
         default:   count_in = count_ff;
      endcase
   end

   assign count_ext = CMPW'(count_in);

   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         cells_ff[i] <= cells_in[i];
      end
      if (cmd.load_rsp) begin
         rsp_ff.status      <= cmd.status;
         rsp_ff.element_out <= cmd.from_cell ? cells_ff[0] : 8'd0;
         rsp_ff.count       <= count_ext[4:0];
         rsp_ff.last        <= cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign count    = count_ff;
   assign rsp_data = rsp_ff;

endmodule

FILE: hw/rtl/alir_ctrl.sv
// ----------------------------------------------------------------------------
// alir_ctrl
// Opcode decode, bounds checks, listing sequencer and result valid.
// ----------------------------------------------------------------------------
module alir_ctrl #(
   parameter int CAPACITY = alir_pkg::CAPACITY_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  alir_pkg::req_payload_type          req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic [$clog2(CAPACITY+1)-1:0]      count,
   output alir_pkg::dp_cmd_type               cmd,
   output logic [$clog2(CAPACITY)-1:0]        idx
);
   import alir_pkg::*;

   localparam int IW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = ((CW > 5) ? CW : 5) + 1;

   typedef enum logic {
      S_IDLE,
      S_LIST
   } state_type;

   state_type       state_ff, state_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [IW-1:0]   k_ff, k_in;
   logic            slot_free;
   logic            accept;
   logic [CMPW-1:0] pos_ext, cnt_ext, pos_dec, cnt_dec;
   logic            is_full, is_empty, emit, at_end;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;

   assign pos_ext  = CMPW'(req_data.position);
   assign cnt_ext  = CMPW'(count);
   assign pos_dec  = pos_ext - CMPW'(1);
   assign cnt_dec  = cnt_ext - CMPW'(1);
   assign is_full  = cnt_ext == CMPW'(CAPACITY);
   assign is_empty = cnt_ext == '0;
   assign emit     = CMPW'(k_ff) < CMPW'(RESULT_LIMIT);
   assign at_end   = k_ff == cnt_dec[IW-1:0];

   always_comb begin
      cmd          = '{op: DP_HOLD, elem: req_data.element_in, load_rsp: 1'b0,
                       status: ST_OK, from_cell: 1'b0, last: 1'b1};
      idx          = '0;
      state_in     = state_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load_rsp = 1'b1;
               unique case (req_data.opcode)
                  OP_INS_END, OP_INS_FRONT, OP_INS_AT: begin
                     if (is_full) begin
                        cmd.status = ST_FULL;
                     end else if (req_data.opcode == OP_INS_END) begin
                        cmd.op = DP_INSERT;
                        idx    = cnt_ext[IW-1:0];
                     end else if (req_data.opcode == OP_INS_FRONT) begin
                        cmd.op = DP_INSERT;
                     end else if (pos_ext == '0 || pos_ext > cnt_ext + CMPW'(1)) begin
                        cmd.status = ST_BADPOS;
                     end else begin
                        cmd.op = DP_INSERT;
                        idx    = pos_dec[IW-1:0];
                     end
                  end
                  OP_REM_END, OP_REM_FRONT, OP_REM_AT: begin
                     if (is_empty) begin
                        cmd.status = ST_EMPTY;
                     end else if (req_data.opcode == OP_REM_END) begin
                        cmd.op = DP_REMOVE;
                        idx    = cnt_dec[IW-1:0];
                     end else if (req_data.opcode == OP_REM_FRONT) begin
                        cmd.op = DP_REMOVE;
                     end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
                        cmd.status = ST_BADPOS;
                     end else begin
                        cmd.op = DP_REMOVE;
                        idx    = pos_dec[IW-1:0];
                     end
                  end
                  OP_LIST: begin
                     if (is_empty) begin
                        cmd.status = ST_EMPTY;
                     end else begin
                        cmd.load_rsp = 1'b0;
                        state_in     = S_LIST;
                        k_in         = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_LIST: begin
            if (!emit || slot_free) begin
               cmd.op        = DP_ROTATE;
               cmd.load_rsp  = emit;
               cmd.from_cell = 1'b1;
               cmd.last      = at_end || (CMPW'(k_ff) == CMPW'(RESULT_LIMIT - 1));
               k_in          = k_ff + IW'(1);
               if (at_end) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (cmd.load_rsp) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         k_ff         <= k_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: hw/rtl/array_list_insert_remove.sv
// Insert, remove, size and error results appear in the cycle after accept;
// a list first enters the listing state, then registers its first element.
// Throughput: 1 transaction per cycle while the result side keeps up and no list runs.
// A list streams one element per cycle, while the result side accepts, through a
// rotation of the cell array; new input is taken only once the list is done.
// Reset clears the element count and the result valid; cell contents are kept.
// ----------------------------------------------------------------------------
// array_list_insert_remove
// Fixed-capacity ordered byte list with positional insert, remove and listing.
// ----------------------------------------------------------------------------
module array_list_insert_remove #(
   parameter int CAPACITY = alir_pkg::CAPACITY_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  alir_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output alir_pkg::rsp_payload_type rsp_data
);
   import alir_pkg::*;

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   dp_cmd_type    cmd;
   logic [IW-1:0] idx;
   logic [CW-1:0] count;

   alir_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .count     (count),
      .cmd       (cmd),
      .idx       (idx)
   );

   alir_dpath #(.CAPACITY(CAPACITY)) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .idx      (idx),
      .count    (count),
      .rsp_data (rsp_data)
   );

endmodule

FILE: hw/rtl/alir_checker.sv
// ----------------------------------------------------------------------------
// alir_checker
// Port-level checks of the array list block, bound to the top level.
// ----------------------------------------------------------------------------
`include "array_list_insert_remove_assert.svh"

module alir_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input alir_pkg::req_payload_type req_data,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input alir_pkg::rsp_payload_type rsp_data
);
   import alir_pkg::*;

   `ALIR_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `ALIR_ASSERT_NXT(a_single_rsp, clock, reset, req_valid && req_ready && req_data.opcode != OP_LIST, rsp_valid && rsp_data.last)
   `ALIR_ASSERT_IMP(a_err_single, clock, reset, rsp_valid && rsp_data.status != ST_OK, rsp_data.last && rsp_data.element_out == 8'd0)
   `ALIR_ASSERT_IMP(a_empty_cnt, clock, reset, rsp_valid && rsp_data.status == ST_EMPTY, rsp_data.count == 5'd0)

endmodule

bind array_list_insert_remove alir_checker u_alir_checker (.*);
